FILE: rtl/graph_labeling_bandwidth_tracker_core_macros.svh
// Assertion macros shared by the graph labelling bandwidth tracker RTL.
// Depends on nothing; users must have signals named clk and rst_n in scope.
`ifndef GRAPH_LABELING_BANDWIDTH_TRACKER_CORE_MACROS_SVH
`define GRAPH_LABELING_BANDWIDTH_TRACKER_CORE_MACROS_SVH

// Condition implies consequence in the same cycle.
`define GLBT_ASSERT_SAME(lbl, cond, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (cond) |-> (cons)) \
        else $error(msg);

// Condition implies consequence in the next cycle.
`define GLBT_ASSERT_NEXT(lbl, cond, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (cond) |=> (cons)) \
        else $error(msg);

`endif

FILE: rtl/glbt_pkg.sv
// Shared types and constants for the graph labelling bandwidth tracker.
// Depends on nothing.
package glbt_pkg;

    localparam int MAX_VERTICES_DEF = 256;
    localparam int MAX_DEGREE_DEF   = 16;

    localparam int CFG_W = 9;
    localparam logic [CFG_W-1:0] CFG_RESET = 9'd256;

    localparam logic [2:0] OP_CLEAR = 3'd0;
    localparam logic [2:0] OP_ADD   = 3'd1;
    localparam logic [2:0] OP_SET   = 3'd2;
    localparam logic [2:0] OP_SWAP  = 3'd3;
    localparam logic [2:0] OP_ALL   = 3'd4;

    localparam logic [1:0] ST_OK    = 2'd0;
    localparam logic [1:0] ST_FULL  = 2'd1;
    localparam logic [1:0] ST_RANGE = 2'd2;

    typedef struct packed {
        logic [7:0] new_label;
        logic [7:0] vertex_b;
        logic [7:0] vertex_a;
        logic [2:0] opcode;
    } cmd_t;

    typedef struct packed {
        logic [8:0] worst_partner;
        logic [8:0] highest_neighbor_label;
        logic [8:0] lowest_neighbor_label;
        logic [7:0] first_critical;
        logic [8:0] critical_count;
        logic [8:0] current_bandwidth;
        logic [1:0] status;
    } res_t;

endpackage

FILE: rtl/graph_labeling_bandwidth_tracker_core.sv
// Top level of the graph labelling bandwidth tracker: ports, count register, output register.
// Depends on glbt_pkg and glbt_ctrl.
//
// Channel  Dir  Payload
// s_*      in   tuser: opcode; tdata: vertex_a, vertex_b, new_label
// m_*      out  tuser: status; tdata: bandwidth, count, first, low, high, partner
// cfg_*    in   vertex count, written whenever cfg_wen is high
//
// After reset a clearing pass over all MAX_VERTICES records initialises the vertex memory.
// One beat is handled at a time; the single read port of the vertex memory sets the pace.
// Add, set and swap refresh one or two vertices and their neighbours, then scan count vertices.
// A result waits in the output register; the next beat is accepted meanwhile.
module graph_labeling_bandwidth_tracker_core
    import glbt_pkg::*;
#(
    parameter int MAX_VERTICES = MAX_VERTICES_DEF,
    parameter int MAX_DEGREE   = MAX_DEGREE_DEF
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             s_tvalid,
    output logic             s_tready,
    input  logic [23:0]      s_tdata,   // vertex_a, vertex_b, new_label
    input  logic [2:0]       s_tuser,   // opcode
    output logic             m_tvalid,
    input  logic             m_tready,
    output logic [55:0]      m_tdata,   // current_bandwidth, critical_count, first_critical,
                                        // lowest_neighbor_label, highest_neighbor_label,
                                        // worst_partner, zero fill
    output logic [1:0]       m_tuser,   // status
    input  logic             cfg_wen,
    input  logic [CFG_W-1:0] cfg_wdata
);

    logic [CFG_W-1:0] count_reg;
    logic             m_valid_reg;
    res_t             res_reg;
    cmd_t             cmd;
    res_t             res;
    logic             res_valid;
    logic             res_ready;

    assign cmd.opcode    = s_tuser;
    assign cmd.vertex_a  = s_tdata[7:0];
    assign cmd.vertex_b  = s_tdata[15:8];
    assign cmd.new_label = s_tdata[23:16];
    assign res_ready     = !m_valid_reg || m_tready;

    glbt_ctrl #(
        .MAX_VERTICES (MAX_VERTICES),
        .MAX_DEGREE   (MAX_DEGREE)
    ) u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_count (count_reg),
        .cmd_valid (s_tvalid),
        .cmd_ready (s_tready),
        .cmd       (cmd),
        .res_valid (res_valid),
        .res_ready (res_ready),
        .res       (res)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg   <= CFG_RESET;
            m_valid_reg <= 1'b0;
        end
        else
        begin
            if (cfg_wen)
            begin
                count_reg <= cfg_wdata;
            end
            if (res_valid && res_ready)
            begin
                m_valid_reg <= 1'b1;
            end
            else if (m_tready)
            begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (res_valid && res_ready)
        begin
            res_reg <= res;
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tuser  = res_reg.status;
    assign m_tdata  = {3'b000,
                       res_reg.worst_partner,
                       res_reg.highest_neighbor_label,
                       res_reg.lowest_neighbor_label,
                       res_reg.first_critical,
                       res_reg.critical_count,
                       res_reg.current_bandwidth};

endmodule

FILE: rtl/glbt_eval.sv
// Per-vertex evaluator: running neighbour label minimum and maximum, worst distance.
// Depends on glbt_pkg only by convention; no package items are needed.
module glbt_eval #(
    parameter int VAW = 8,
    parameter int NW  = 9
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  init,
    input  logic [NW-1:0]         count,
    input  logic                  upd,
    input  logic [VAW-1:0]        nb_label,
    input  logic [VAW-1:0]        nb_vertex,
    input  logic [VAW-1:0]        own_label,
    output logic signed [VAW+1:0] lo,
    output logic signed [VAW:0]   hi,
    output logic signed [VAW+1:0] wd,
    output logic signed [VAW:0]   wn
);

    logic signed [VAW+1:0] lo_reg;
    logic signed [VAW:0]   hi_reg;
    logic signed [VAW:0]   arglo_reg;
    logic signed [VAW:0]   arghi_reg;
    logic signed [VAW+1:0] l_wide;
    logic signed [VAW:0]   l_narrow;
    logic signed [VAW+1:0] own_wide;
    logic signed [VAW+1:0] dlo;
    logic signed [VAW+1:0] dhi;

    assign l_wide   = $signed({2'b00, nb_label});
    assign l_narrow = $signed({1'b0, nb_label});
    assign own_wide = $signed({2'b00, own_label});

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            lo_reg    <= '0;
            hi_reg    <= '1;
            arglo_reg <= '1;
            arghi_reg <= '1;
        end
        else if (init)
        begin
            lo_reg    <= $signed((VAW+2)'(count));
            hi_reg    <= '1;
            arglo_reg <= '1;
            arghi_reg <= '1;
        end
        else if (upd)
        begin
            if (l_wide < lo_reg)
            begin
                lo_reg    <= l_wide;
                arglo_reg <= $signed({1'b0, nb_vertex});
            end
            if (l_narrow > hi_reg)
            begin
                hi_reg    <= l_narrow;
                arghi_reg <= $signed({1'b0, nb_vertex});
            end
        end
    end

    assign dlo = own_wide - lo_reg;
    assign dhi = $signed((VAW+2)'(hi_reg)) - own_wide;
    assign lo  = lo_reg;
    assign hi  = hi_reg;
    assign wd  = (dlo > dhi) ? dlo : dhi;
    assign wn  = (dlo > dhi) ? arglo_reg : arghi_reg;

endmodule

FILE: rtl/glbt_scan.sv
// Bandwidth scan accumulator: largest worst distance, its count and lowest vertex.
// Depends on nothing outside this file.
module glbt_scan #(
    parameter int VAW = 8,
    parameter int NW  = 9
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  start,
    input  logic                  en,
    input  logic signed [VAW+1:0] wd,
    input  logic [VAW-1:0]        vertex,
    output logic signed [VAW+1:0] bw,
    output logic [NW-1:0]         total,
    output logic [VAW-1:0]        first
);

    logic signed [VAW+1:0] bw_reg;
    logic [NW-1:0]         total_reg;
    logic [VAW-1:0]        first_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            bw_reg    <= '1;
            total_reg <= '0;
            first_reg <= '0;
        end
        else if (start)
        begin
            bw_reg    <= '1;
            total_reg <= '0;
            first_reg <= '0;
        end
        else if (en)
        begin
            priority if (wd > bw_reg)
            begin
                bw_reg    <= wd;
                total_reg <= NW'(1);
                first_reg <= vertex;
            end
            else if (wd == bw_reg)
            begin
                if (total_reg == '0)
                begin
                    first_reg <= vertex;
                end
                total_reg <= total_reg + NW'(1);
            end
        end
    end

    assign bw    = bw_reg;
    assign total = total_reg;
    assign first = first_reg;

endmodule

FILE: rtl/glbt_ctrl.sv
// Sequencer with the vertex record memory and the neighbour list memory.
// Depends on glbt_pkg, glbt_eval, glbt_scan and the assertion macro header.
`include "graph_labeling_bandwidth_tracker_core_macros.svh"

module glbt_ctrl
    import glbt_pkg::*;
#(
    parameter int MAX_VERTICES = MAX_VERTICES_DEF,
    parameter int MAX_DEGREE   = MAX_DEGREE_DEF
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic [CFG_W-1:0] cfg_count,
    input  logic             cmd_valid,
    output logic             cmd_ready,
    input  cmd_t             cmd,
    output logic             res_valid,
    input  logic             res_ready,
    output res_t             res
);

    localparam int VAW = $clog2(MAX_VERTICES);
    localparam int NW  = $clog2(MAX_VERTICES + 1);
    localparam int DW  = $clog2(MAX_DEGREE + 1);
    localparam int NAW = $clog2(MAX_VERTICES * MAX_DEGREE);
    localparam int CW  = NW + 8;
    localparam int RST_N_EFF = (MAX_VERTICES < 256) ? MAX_VERTICES : 256;

    localparam logic [4:0] S_INIT     = 5'd0;
    localparam logic [4:0] S_IDLE     = 5'd1;
    localparam logic [4:0] S_DEC      = 5'd2;
    localparam logic [4:0] S_CLR      = 5'd3;
    localparam logic [4:0] S_CLR_LAST = 5'd4;
    localparam logic [4:0] S_ADD_CHK  = 5'd5;
    localparam logic [4:0] S_SET_RD   = 5'd6;
    localparam logic [4:0] S_SWP_A    = 5'd7;
    localparam logic [4:0] S_SWP_B    = 5'd8;
    localparam logic [4:0] S_SWP_W    = 5'd9;
    localparam logic [4:0] S_AR_START = 5'd10;
    localparam logic [4:0] S_AR_NEXT  = 5'd11;
    localparam logic [4:0] S_AR_NB    = 5'd12;
    localparam logic [4:0] S_R_START  = 5'd13;
    localparam logic [4:0] S_R_HDR    = 5'd14;
    localparam logic [4:0] S_R_NB     = 5'd15;
    localparam logic [4:0] S_R_LAB    = 5'd16;
    localparam logic [4:0] S_R_WR     = 5'd17;
    localparam logic [4:0] S_ALL_NEXT = 5'd18;
    localparam logic [4:0] S_SCAN     = 5'd19;
    localparam logic [4:0] S_SCAN_LST = 5'd20;
    localparam logic [4:0] S_RPT      = 5'd21;
    localparam logic [4:0] S_RPT_W    = 5'd22;

    typedef struct packed {
        logic [DW-1:0]  cnt;
        logic [VAW-1:0] label;
        logic [NW-1:0]  minl;
        logic [VAW:0]   maxl;
        logic [VAW+1:0] wd;
        logic [VAW:0]   wn;
    } vrec_t;

    function automatic logic [NAW-1:0] nb_addr(input logic [VAW-1:0] v,
                                               input logic [DW-1:0] k);
        nb_addr = NAW'(NAW'(v) * NAW'(MAX_DEGREE) + NAW'(k));
    endfunction

    vrec_t          vmem [MAX_VERTICES];
    logic [7:0]     nmem [MAX_VERTICES * MAX_DEGREE];

    vrec_t          vrd_reg;
    logic [7:0]     nrd_reg;
    logic [VAW-1:0] vra;
    logic           vwe;
    logic [VAW-1:0] vwa;
    vrec_t          vwd;
    logic [NAW-1:0] nra;
    logic           nwe;
    logic [NAW-1:0] nwa;
    logic [7:0]     nwd;

    logic [4:0]     state_reg, state_next;
    cmd_t           cmd_reg, cmd_next;
    logic [NW-1:0]  n_reg, n_next;
    logic [1:0]     st_reg, st_next;
    logic [VAW-1:0] idx_reg, idx_next;
    logic           pend_reg, pend_next;
    logic [VAW-1:0] pidx_reg, pidx_next;
    logic [VAW-1:0] root_reg, root_next;
    logic [DW-1:0]  root_cnt_reg, root_cnt_next;
    logic [DW-1:0]  ok_reg, ok_next;
    logic           ar_first_reg, ar_first_next;
    logic           second_reg, second_next;
    logic           ret_all_reg, ret_all_next;
    logic [VAW-1:0] v_reg, v_next;
    logic [VAW-1:0] v_lab_reg, v_lab_next;
    logic [DW-1:0]  v_cnt_reg, v_cnt_next;
    logic [DW-1:0]  k_reg, k_next;
    logic [VAW-1:0] u_reg, u_next;
    vrec_t          rec_reg, rec_next;

    logic [NW-1:0]         n_eff;
    logic                  a_ok, b_ok, lab_ok, a_mem;
    logic [VAW-1:0]        a_idx, b_idx;
    logic                  ev_init, ev_upd;
    logic [VAW-1:0]        ev_own;
    logic signed [VAW+1:0] ev_lo, ev_wd;
    logic signed [VAW:0]   ev_hi, ev_wn;
    logic                  sc_start, sc_en;
    logic signed [VAW+1:0] sc_bw;
    logic [NW-1:0]         sc_total;
    logic [VAW-1:0]        sc_first;

    always_ff @(posedge clk)
    begin
        if (vwe)
        begin
            vmem[vwa] <= vwd;
        end
        vrd_reg <= vmem[vra];
    end

    always_ff @(posedge clk)
    begin
        if (nwe)
        begin
            nmem[nwa] <= nwd;
        end
        nrd_reg <= nmem[nra];
    end

    glbt_eval #(.VAW(VAW), .NW(NW)) u_eval (
        .clk       (clk),
        .rst_n     (rst_n),
        .init      (ev_init),
        .count     (n_reg),
        .upd       (ev_upd),
        .nb_label  (vrd_reg.label),
        .nb_vertex (u_reg),
        .own_label (ev_own),
        .lo        (ev_lo),
        .hi        (ev_hi),
        .wd        (ev_wd),
        .wn        (ev_wn)
    );

    glbt_scan #(.VAW(VAW), .NW(NW)) u_scan (
        .clk    (clk),
        .rst_n  (rst_n),
        .start  (sc_start),
        .en     (sc_en),
        .wd     ($signed(vrd_reg.wd)),
        .vertex (pidx_reg),
        .bw     (sc_bw),
        .total  (sc_total),
        .first  (sc_first)
    );

    assign n_eff = (cfg_count == '0) ? NW'(1)
                 : (CW'(cfg_count) > CW'(MAX_VERTICES)) ? NW'(MAX_VERTICES)
                 : NW'(cfg_count);

    assign a_ok   = CW'(cmd_reg.vertex_a) < CW'(n_reg);
    assign b_ok   = CW'(cmd_reg.vertex_b) < CW'(n_reg);
    assign lab_ok = CW'(cmd_reg.new_label) < CW'(n_reg);
    assign a_mem  = CW'(cmd_reg.vertex_a) < CW'(MAX_VERTICES);
    assign a_idx  = VAW'(cmd_reg.vertex_a);
    assign b_idx  = VAW'(cmd_reg.vertex_b);
    assign ev_own = ((state_reg == S_CLR) || (state_reg == S_CLR_LAST)) ? pidx_reg : v_lab_reg;
    assign sc_en  = pend_reg && ((state_reg == S_SCAN) || (state_reg == S_SCAN_LST));
    assign cmd_ready = (state_reg == S_IDLE);

    always_comb
    begin
        state_next    = state_reg;
        cmd_next      = cmd_reg;
        n_next        = n_reg;
        st_next       = st_reg;
        idx_next      = idx_reg;
        pend_next     = pend_reg;
        pidx_next     = pidx_reg;
        root_next     = root_reg;
        root_cnt_next = root_cnt_reg;
        ok_next       = ok_reg;
        ar_first_next = ar_first_reg;
        second_next   = second_reg;
        ret_all_next  = ret_all_reg;
        v_next        = v_reg;
        v_lab_next    = v_lab_reg;
        v_cnt_next    = v_cnt_reg;
        k_next        = k_reg;
        u_next        = u_reg;
        rec_next      = rec_reg;
        vra      = v_reg;
        vwe      = 1'b0;
        vwa      = v_reg;
        vwd      = vrd_reg;
        nra      = nb_addr(v_reg, k_reg);
        nwe      = 1'b0;
        nwa      = nb_addr(a_idx, vrd_reg.cnt);
        nwd      = cmd_reg.vertex_b;
        ev_init  = 1'b0;
        ev_upd   = 1'b0;
        sc_start = 1'b0;
        res_valid = 1'b0;
        res.status                 = st_reg;
        res.current_bandwidth      = 9'(sc_bw);
        res.critical_count         = 9'(sc_total);
        res.first_critical         = 8'(sc_first);
        res.lowest_neighbor_label  = a_mem ? 9'(vrd_reg.minl) : 9'(n_reg);
        res.highest_neighbor_label = a_mem ? 9'($signed(vrd_reg.maxl)) : '1;
        res.worst_partner          = a_mem ? 9'($signed(vrd_reg.wn)) : '1;

        unique case (state_reg)
            S_INIT:
            begin
                vwe       = 1'b1;
                vwa       = idx_reg;
                vwd.cnt   = '0;
                vwd.label = idx_reg;
                vwd.minl  = NW'(RST_N_EFF);
                vwd.maxl  = '1;
                vwd.wd    = '1;
                vwd.wn    = '1;
                idx_next  = idx_reg + VAW'(1);
                if (CW'(idx_reg) == CW'(MAX_VERTICES - 1))
                begin
                    idx_next   = '0;
                    state_next = S_IDLE;
                end
            end
            S_IDLE:
            begin
                if (cmd_valid)
                begin
                    cmd_next   = cmd;
                    n_next     = n_eff;
                    st_next    = ST_OK;
                    state_next = S_DEC;
                end
            end
            S_DEC:
            begin
                vra = a_idx;
                unique case (cmd_reg.opcode)
                    OP_CLEAR:
                    begin
                        idx_next   = '0;
                        pend_next  = 1'b0;
                        ev_init    = 1'b1;
                        state_next = S_CLR;
                    end
                    OP_ADD:
                    begin
                        if (a_ok && b_ok)
                        begin
                            state_next = S_ADD_CHK;
                        end
                        else
                        begin
                            st_next    = ST_RANGE;
                            state_next = S_RPT;
                        end
                    end
                    OP_SET:
                    begin
                        if (a_ok && lab_ok)
                        begin
                            state_next = S_SET_RD;
                        end
                        else
                        begin
                            st_next    = ST_RANGE;
                            state_next = S_RPT;
                        end
                    end
                    OP_SWAP:
                    begin
                        if (a_ok && b_ok)
                        begin
                            state_next = S_SWP_A;
                        end
                        else
                        begin
                            st_next    = ST_RANGE;
                            state_next = S_RPT;
                        end
                    end
                    OP_ALL:
                    begin
                        idx_next     = '0;
                        v_next       = '0;
                        ret_all_next = 1'b1;
                        state_next   = S_R_START;
                    end
                    default:
                    begin
                        state_next = S_RPT;
                    end
                endcase
            end
            S_CLR, S_CLR_LAST:
            begin
                vra = idx_reg;
                if (pend_reg)
                begin
                    vwe       = 1'b1;
                    vwa       = pidx_reg;
                    vwd.cnt   = '0;
                    vwd.label = pidx_reg;
                    if (CW'(pidx_reg) < CW'(n_reg))
                    begin
                        vwd.minl = n_reg;
                        vwd.maxl = '1;
                        vwd.wd   = ev_wd;
                        vwd.wn   = ev_wn;
                    end
                end
                if (state_reg == S_CLR)
                begin
                    pend_next = 1'b1;
                    pidx_next = idx_reg;
                    idx_next  = idx_reg + VAW'(1);
                    if (CW'(idx_reg) == CW'(MAX_VERTICES - 1))
                    begin
                        state_next = S_CLR_LAST;
                    end
                end
                else
                begin
                    idx_next   = '0;
                    pend_next  = 1'b0;
                    sc_start   = 1'b1;
                    state_next = S_SCAN;
                end
            end
            S_ADD_CHK:
            begin
                if (CW'(vrd_reg.cnt) >= CW'(MAX_DEGREE))
                begin
                    st_next    = ST_FULL;
                    state_next = S_RPT;
                end
                else
                begin
                    nwe         = 1'b1;
                    vwe         = 1'b1;
                    vwa         = a_idx;
                    vwd.cnt     = vrd_reg.cnt + DW'(1);
                    root_next   = a_idx;
                    second_next = 1'b0;
                    state_next  = S_AR_START;
                end
            end
            S_SET_RD:
            begin
                vwe         = 1'b1;
                vwa         = a_idx;
                vwd.label   = VAW'(cmd_reg.new_label);
                root_next   = a_idx;
                second_next = 1'b0;
                state_next  = S_AR_START;
            end
            S_SWP_A:
            begin
                rec_next   = vrd_reg;
                vra        = b_idx;
                state_next = S_SWP_B;
            end
            S_SWP_B:
            begin
                vwe            = 1'b1;
                vwa            = a_idx;
                vwd            = rec_reg;
                vwd.label      = vrd_reg.label;
                rec_next       = vrd_reg;
                rec_next.label = rec_reg.label;
                state_next     = S_SWP_W;
            end
            S_SWP_W:
            begin
                vwe         = 1'b1;
                vwa         = b_idx;
                vwd         = rec_reg;
                root_next   = a_idx;
                second_next = 1'b0;
                state_next  = S_AR_START;
            end
            S_AR_START:
            begin
                v_next        = root_reg;
                ok_next       = '0;
                ar_first_next = 1'b1;
                ret_all_next  = 1'b0;
                state_next    = S_R_START;
            end
            S_AR_NEXT:
            begin
                nra = nb_addr(root_reg, ok_reg);
                if (ok_reg == root_cnt_reg)
                begin
                    if ((cmd_reg.opcode == OP_SWAP) && !second_reg)
                    begin
                        root_next   = b_idx;
                        second_next = 1'b1;
                        state_next  = S_AR_START;
                    end
                    else
                    begin
                        idx_next   = '0;
                        pend_next  = 1'b0;
                        sc_start   = 1'b1;
                        state_next = S_SCAN;
                    end
                end
                else
                begin
                    state_next = S_AR_NB;
                end
            end
            S_AR_NB:
            begin
                v_next     = VAW'(nrd_reg);
                ok_next    = ok_reg + DW'(1);
                state_next = S_R_START;
            end
            S_R_START:
            begin
                vra        = v_reg;
                state_next = S_R_HDR;
            end
            S_R_HDR:
            begin
                v_lab_next = vrd_reg.label;
                v_cnt_next = vrd_reg.cnt;
                ev_init    = 1'b1;
                k_next     = '0;
                nra        = nb_addr(v_reg, '0);
                if (ar_first_reg)
                begin
                    root_cnt_next = vrd_reg.cnt;
                    ar_first_next = 1'b0;
                end
                if (vrd_reg.cnt == '0)
                begin
                    state_next = S_R_WR;
                end
                else
                begin
                    state_next = S_R_NB;
                end
            end
            S_R_NB:
            begin
                vra        = VAW'(nrd_reg);
                u_next     = VAW'(nrd_reg);
                state_next = S_R_LAB;
            end
            S_R_LAB:
            begin
                ev_upd = 1'b1;
                k_next = k_reg + DW'(1);
                nra    = nb_addr(v_reg, k_reg + DW'(1));
                if ((k_reg + DW'(1)) == v_cnt_reg)
                begin
                    state_next = S_R_WR;
                end
                else
                begin
                    state_next = S_R_NB;
                end
            end
            S_R_WR:
            begin
                vwe       = 1'b1;
                vwa       = v_reg;
                vwd.cnt   = v_cnt_reg;
                vwd.label = v_lab_reg;
                vwd.minl  = NW'(ev_lo);
                vwd.maxl  = ev_hi;
                vwd.wd    = ev_wd;
                vwd.wn    = ev_wn;
                state_next = ret_all_reg ? S_ALL_NEXT : S_AR_NEXT;
            end
            S_ALL_NEXT:
            begin
                if ((CW'(idx_reg) + CW'(1)) == CW'(n_reg))
                begin
                    idx_next   = '0;
                    pend_next  = 1'b0;
                    sc_start   = 1'b1;
                    state_next = S_SCAN;
                end
                else
                begin
                    idx_next   = idx_reg + VAW'(1);
                    v_next     = idx_reg + VAW'(1);
                    state_next = S_R_START;
                end
            end
            S_SCAN:
            begin
                vra       = idx_reg;
                pend_next = 1'b1;
                pidx_next = idx_reg;
                idx_next  = idx_reg + VAW'(1);
                if ((CW'(idx_reg) + CW'(1)) == CW'(n_reg))
                begin
                    state_next = S_SCAN_LST;
                end
            end
            S_SCAN_LST:
            begin
                idx_next   = '0;
                pend_next  = 1'b0;
                state_next = S_RPT;
            end
            S_RPT:
            begin
                vra        = a_idx;
                state_next = S_RPT_W;
            end
            S_RPT_W:
            begin
                vra       = a_idx;
                res_valid = 1'b1;
                if (res_ready)
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= S_INIT;
            idx_reg      <= '0;
            pend_reg     <= 1'b0;
            ar_first_reg <= 1'b0;
            second_reg   <= 1'b0;
            ret_all_reg  <= 1'b0;
            st_reg       <= ST_OK;
            n_reg        <= NW'(RST_N_EFF);
        end
        else
        begin
            state_reg    <= state_next;
            idx_reg      <= idx_next;
            pend_reg     <= pend_next;
            ar_first_reg <= ar_first_next;
            second_reg   <= second_next;
            ret_all_reg  <= ret_all_next;
            st_reg       <= st_next;
            n_reg        <= n_next;
        end
    end

    always_ff @(posedge clk)
    begin
        cmd_reg      <= cmd_next;
        pidx_reg     <= pidx_next;
        root_reg     <= root_next;
        root_cnt_reg <= root_cnt_next;
        ok_reg       <= ok_next;
        v_reg        <= v_next;
        v_lab_reg    <= v_lab_next;
        v_cnt_reg    <= v_cnt_next;
        k_reg        <= k_next;
        u_reg        <= u_next;
        rec_reg      <= rec_next;
    end

    `GLBT_ASSERT_SAME(a_idle_no_write, state_reg == S_IDLE, !vwe && !nwe,
        "Memory written while idle.")
    `GLBT_ASSERT_NEXT(a_accept_decode, cmd_valid && cmd_ready, state_reg == S_DEC,
        "Accepted beat not decoded.")
    `GLBT_ASSERT_SAME(a_walk_bound, state_reg == S_R_LAB, k_reg < v_cnt_reg,
        "Neighbour walk ran past the list length.")
    `GLBT_ASSERT_SAME(a_full_only_add, res_valid && (res.status == ST_FULL),
        cmd_reg.opcode == OP_ADD, "List full reported for an operation other than add.")

endmodule

FILE: tb/sv/graph_labeling_bandwidth_tracker_core_test.sv
// Self-checking testbench for graph_labeling_bandwidth_tracker_core: it streams graph
// commands, predicts every result with a scoreboard of its own and compares each field.
// Depends on glbt_pkg and the RTL of the tracker core.
`timescale 1ns / 1ps

module graph_labeling_bandwidth_tracker_core_test
    import glbt_pkg::*;
();

    localparam int NV  = 256;
    localparam int DEG = 16;

    class tracker_scoreboard;
        int vcount;
        int nbr[NV * DEG];
        int deg[NV];
        int lab[NV];
        int lo_lab[NV];
        int hi_lab[NV];
        int worst[NV];
        int partner[NV];
        int bw;
        int crit_total;
        int crit_first;
        res_t expected_q[$];
        int errors;

        function new();
            vcount = NV;
            errors = 0;
            for (int i = 0; i < NV; i++)
            begin
                deg[i] = 0;
                lab[i] = i;
                lo_lab[i] = NV;
                hi_lab[i] = -1;
                worst[i] = -1;
                partner[i] = -1;
            end
            for (int i = 0; i < NV * DEG; i++)
                nbr[i] = 0;
            bw = -1;
            crit_total = 0;
            crit_first = 0;
        endfunction

        function int eff();
            if (vcount < 1)
                return 1;
            if (vcount > NV)
                return NV;
            return vcount;
        endfunction

        function void refresh(int v);
            int lo;
            int hi;
            int arg_lo;
            int arg_hi;
            int u;
            lo = eff();
            hi = -1;
            arg_lo = -1;
            arg_hi = -1;
            for (int k = 0; k < deg[v]; k++)
            begin
                u = nbr[v * DEG + k];
                if (lab[u] < lo)
                begin
                    lo = lab[u];
                    arg_lo = u;
                end
                if (lab[u] > hi)
                begin
                    hi = lab[u];
                    arg_hi = u;
                end
            end
            lo_lab[v] = lo;
            hi_lab[v] = hi;
            if (lab[v] - lo > hi - lab[v])
            begin
                worst[v] = lab[v] - lo;
                partner[v] = arg_lo;
            end
            else
            begin
                worst[v] = hi - lab[v];
                partner[v] = arg_hi;
            end
        endfunction

        function void refresh_around(int v);
            refresh(v);
            for (int k = 0; k < deg[v]; k++)
                refresh(nbr[v * DEG + k]);
        endfunction

        function void rescan();
            bw = -1;
            crit_total = 0;
            crit_first = 0;
            for (int v = 0; v < eff(); v++)
            begin
                if (worst[v] > bw)
                begin
                    bw = worst[v];
                    crit_total = 0;
                end
                if (worst[v] == bw)
                begin
                    if (crit_total == 0)
                        crit_first = v;
                    crit_total++;
                end
            end
        endfunction

        function void note_command(cmd_t c);
            int n;
            int a;
            int b;
            int t;
            res_t r;
            n = eff();
            a = int'(c.vertex_a);
            b = int'(c.vertex_b);
            r.status = ST_OK;
            case (c.opcode)
                OP_CLEAR:
                begin
                    for (int i = 0; i < NV; i++)
                    begin
                        deg[i] = 0;
                        lab[i] = i;
                    end
                    for (int i = 0; i < n; i++)
                        refresh(i);
                    rescan();
                end
                OP_ADD:
                begin
                    if (a >= n || b >= n)
                        r.status = ST_RANGE;
                    else if (deg[a] >= DEG)
                        r.status = ST_FULL;
                    else
                    begin
                        nbr[a * DEG + deg[a]] = b;
                        deg[a]++;
                        refresh_around(a);
                        rescan();
                    end
                end
                OP_SET:
                begin
                    if (a >= n || int'(c.new_label) >= n)
                        r.status = ST_RANGE;
                    else
                    begin
                        lab[a] = int'(c.new_label);
                        refresh_around(a);
                        rescan();
                    end
                end
                OP_SWAP:
                begin
                    if (a >= n || b >= n)
                        r.status = ST_RANGE;
                    else
                    begin
                        t = lab[a];
                        lab[a] = lab[b];
                        lab[b] = t;
                        refresh_around(a);
                        refresh_around(b);
                        rescan();
                    end
                end
                OP_ALL:
                begin
                    for (int i = 0; i < n; i++)
                        refresh(i);
                    rescan();
                end
                default:
                    ;
            endcase
            r.current_bandwidth = 9'(bw);
            r.critical_count = 9'(crit_total);
            r.first_critical = 8'(crit_first);
            r.lowest_neighbor_label = 9'(lo_lab[a]);
            r.highest_neighbor_label = 9'(hi_lab[a]);
            r.worst_partner = 9'(partner[a]);
            expected_q = {expected_q, r};
        endfunction

        task report(string what, int got, int want);
            $display("mismatch at %0t: %s got %0h expected %0h", $time, what, got, want);
            errors++;
        endtask

        task check_result(res_t r);
            res_t e;
            if (expected_q.size() == 0)
            begin
                report("unexpected beat", int'(r.status), 0);
                return;
            end
            e = expected_q.pop_front();
            if (r.status != e.status)
                report("status", int'(r.status), int'(e.status));
            if (r.current_bandwidth != e.current_bandwidth)
                report("current_bandwidth", int'(r.current_bandwidth),
                       int'(e.current_bandwidth));
            if (r.critical_count != e.critical_count)
                report("critical_count", int'(r.critical_count), int'(e.critical_count));
            if (r.first_critical != e.first_critical)
                report("first_critical", int'(r.first_critical), int'(e.first_critical));
            if (r.lowest_neighbor_label != e.lowest_neighbor_label)
                report("lowest_neighbor_label", int'(r.lowest_neighbor_label),
                       int'(e.lowest_neighbor_label));
            if (r.highest_neighbor_label != e.highest_neighbor_label)
                report("highest_neighbor_label", int'(r.highest_neighbor_label),
                       int'(e.highest_neighbor_label));
            if (r.worst_partner != e.worst_partner)
                report("worst_partner", int'(r.worst_partner), int'(e.worst_partner));
        endtask
    endclass

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [23:0] s_tdata = '0;
    logic [2:0]  s_tuser = '0;
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [55:0] m_tdata;
    logic [1:0]  m_tuser;
    logic        cfg_wen = 1'b0;
    logic [CFG_W-1:0] cfg_wdata = '0;

    tracker_scoreboard sb = new();
    int accepted = 0;
    int hold_cycles = 0;
    bit hold_req = 0;
    int rx_mode = 0;
    int rx_tick = 0;

    always #5 clk = ~clk;

    graph_labeling_bandwidth_tracker_core uut (
        .clk(clk), .rst_n(rst_n),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tuser(m_tuser),
        .cfg_wen(cfg_wen), .cfg_wdata(cfg_wdata)
    );

    always @(posedge clk)
    begin
        res_t r;
        cmd_t c;
        if (rst_n && m_tvalid && m_tready)
        begin
            r.status = m_tuser;
            r.current_bandwidth = m_tdata[8:0];
            r.critical_count = m_tdata[17:9];
            r.first_critical = m_tdata[25:18];
            r.lowest_neighbor_label = m_tdata[34:26];
            r.highest_neighbor_label = m_tdata[43:35];
            r.worst_partner = m_tdata[52:44];
            sb.check_result(r);
        end
        if (rst_n && s_tvalid && s_tready)
        begin
            c.opcode = s_tuser;
            c.vertex_a = s_tdata[7:0];
            c.vertex_b = s_tdata[15:8];
            c.new_label = s_tdata[23:16];
            sb.note_command(c);
            accepted <= accepted + 1;
        end
    end

    always @(negedge clk)
    begin
        rx_tick++;
        if (rx_tick % 300 == 0)
            rx_mode = $urandom_range(0, 2);
        if (hold_req)
        begin
            hold_req = 0;
            hold_cycles = 600;
        end
        if (hold_cycles > 0)
        begin
            hold_cycles--;
            m_tready <= 1'b0;
        end
        else if (rx_mode == 0)
            m_tready <= 1'b1;
        else if (rx_mode == 1)
            m_tready <= ($urandom_range(0, 3) != 0);
        else
            m_tready <= (rx_tick % 9 < 4);
    end

    task send(logic [2:0] op, logic [7:0] a, logic [7:0] b, logic [7:0] l);
        int before_cnt;
        before_cnt = accepted;
        s_tvalid <= 1'b1;
        s_tuser <= op;
        s_tdata <= {l, b, a};
        do
            @(negedge clk);
        while (accepted == before_cnt);
    endtask

    task pause(int n);
        s_tvalid <= 1'b0;
        repeat (n) @(negedge clk);
    endtask

    task drain();
        s_tvalid <= 1'b0;
        while (sb.expected_q.size() != 0)
            @(negedge clk);
        repeat (40) @(negedge clk);
    endtask

    task write_count(int v);
        cfg_wen <= 1'b1;
        cfg_wdata <= CFG_W'(v);
        @(negedge clk);
        cfg_wen <= 1'b0;
        sb.vcount = v;
        @(negedge clk);
    endtask

    function logic [7:0] pick_vertex(int n);
        if ($urandom_range(0, 9) == 0)
            return 8'($urandom_range(0, 255));
        return 8'($urandom_range(0, n - 1));
    endfunction

    task random_phase(int items);
        int n;
        int r;
        int left;
        int burst;
        logic [2:0] op;
        n = sb.eff();
        left = items;
        while (left > 0)
        begin
            burst = $urandom_range(1, 20);
            while (burst > 0 && left > 0)
            begin
                r = $urandom_range(0, 99);
                if (r < 45)
                    op = OP_ADD;
                else if (r < 65)
                    op = OP_SET;
                else if (r < 86)
                    op = OP_SWAP;
                else if (r < 89)
                    op = OP_ALL;
                else if (r < 92)
                    op = OP_CLEAR;
                else
                    op = 3'($urandom_range(5, 7));
                if (left == items / 2)
                    hold_req = 1;
                send(op, pick_vertex(n), pick_vertex(n), pick_vertex(n));
                burst--;
                left--;
            end
            if ($urandom_range(0, 2) != 0)
                pause($urandom_range(1, 8));
        end
        drain();
    endtask

    initial
    begin
        int phase_counts[9] = '{4, 16, 1, 0, 300, 256, 40, 9, 256};
        repeat (7) @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        send(OP_ALL, 0, 0, 0);
        send(OP_ADD, 0, 255, 0);
        send(OP_ADD, 255, 0, 0);
        send(OP_ADD, 3, 3, 0);
        send(OP_SET, 10, 0, 255);
        send(OP_SWAP, 0, 255, 0);
        send(OP_SWAP, 7, 7, 0);
        send(3'd5, 255, 255, 255);
        send(3'd6, 0, 0, 0);
        send(3'd7, 128, 64, 32);
        send(OP_CLEAR, 255, 0, 0);
        drain();

        write_count(4);
        for (int i = 0; i < 17; i++)
            send(OP_ADD, 1, 8'(i % 4), 0);
        send(OP_ADD, 7, 0, 0);
        send(OP_ADD, 0, 4, 0);
        send(OP_SET, 2, 0, 4);
        send(OP_SET, 200, 0, 1);
        send(OP_SWAP, 0, 9, 0);
        send(OP_ALL, 1, 0, 0);
        drain();

        foreach (phase_counts[i])
        begin
            write_count(phase_counts[i]);
            random_phase(phase_counts[i] >= 256 ? 100 : 135);
        end

        drain();
        if (sb.errors == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end

    initial
    begin
        #100ms;
        $display("RESULT: ERROR");
        $finish;
    end

endmodule
